// ===== rtl/spq_pkg.sv =====
package spq_pkg;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned SEV_W  = 8;
  localparam int unsigned PAY_W  = 32;
  localparam int unsigned IN_W   = 48;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_INS_RD   = 6'b000010,
    ST_INS_CMP  = 6'b000100,
    ST_REM_RD   = 6'b001000,
    ST_REM_WAIT = 6'b010000,
    ST_RESULT   = 6'b100000
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic set_k;
    logic dec_k;
    logic rd_tail;
    logic rd_head;
    logic wr_new;
    logic wr_old;
    logic ins_done;
    logic pop;
    logic clear;
    logic push_out;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic is_ins;
    logic is_rem;
    logic is_clr;
    logic full;
    logic empty;
    logic k_zero;
    logic key_gt;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/spq_ram.sv =====
module spq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/spq_ctrl.sv =====
module spq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  spq_pkg::sts_t sts_i,
  output spq_pkg::cmd_t cmd_o
);
  import spq_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) begin
          cmd_o.load = 1'b1;
          priority if (sts_i.is_ins && !sts_i.full) begin
            cmd_o.set_k = 1'b1;
            state_d     = ST_INS_RD;
          end else if (sts_i.is_rem && !sts_i.empty) begin
            state_d = ST_REM_RD;
          end else begin
            cmd_o.clear = sts_i.is_clr && !sts_i.empty;
            state_d     = ST_RESULT;
          end
        end
      end
      ST_INS_RD: begin
        if (sts_i.k_zero) begin
          cmd_o.wr_new   = 1'b1;
          cmd_o.ins_done = 1'b1;
          state_d        = ST_RESULT;
        end else begin
          cmd_o.rd_tail = 1'b1;
          state_d       = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (sts_i.key_gt) begin
          cmd_o.wr_new   = 1'b1;
          cmd_o.ins_done = 1'b1;
          state_d        = ST_RESULT;
        end else begin
          cmd_o.wr_old = 1'b1;
          cmd_o.dec_k  = 1'b1;
          state_d      = ST_INS_RD;
        end
      end
      ST_REM_RD: begin
        cmd_o.rd_head = 1'b1;
        state_d       = ST_REM_WAIT;
      end
      ST_REM_WAIT: begin
        cmd_o.pop = 1'b1;
        state_d   = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.push_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/spq_dp.sv =====
module spq_dp #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned OUT_W = 48
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  spq_pkg::cmd_t             cmd_i,
  output spq_pkg::sts_t             sts_o,
  input  logic                      s_valid_i,
  input  logic [spq_pkg::IN_W-1:0]  s_data_i,
  output logic                      m_valid_o,
  input  logic                      m_ready_i,
  output logic [OUT_W-1:0]          m_data_o
);
  import spq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [AW-1:0]    head_q;
  logic [CW-1:0]    count_q;
  logic [AW-1:0]    k_q;
  logic [SEV_W-1:0] sev_q;
  logic [PAY_W-1:0] pay_q;
  logic             res_ok_q;
  logic [SEV_W-1:0] res_sev_q;
  logic [PAY_W-1:0] res_pay_q;
  logic             m_valid_q;
  logic [OUT_W-1:0] m_data_q;

  logic [FUNC_W-1:0] in_func;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic [SEV_W-1:0]  key_rdata;
  logic [PAY_W-1:0]  pay_rdata;
  logic [SEV_W-1:0]  key_wdata;
  logic [PAY_W-1:0]  pay_wdata;
  logic              ram_we;

  function automatic logic [AW-1:0] slot_of(logic [AW-1:0] head, logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign in_func = s_data_i[FUNC_W-1:0];

  assign sts_o.in_valid = s_valid_i;
  assign sts_o.is_ins   = in_func == FUNC_INSERT;
  assign sts_o.is_rem   = in_func == FUNC_REMOVE;
  assign sts_o.is_clr   = in_func == FUNC_CLEAR;
  assign sts_o.full     = count_q == CW'(DEPTH);
  assign sts_o.empty    = count_q == '0;
  assign sts_o.k_zero   = k_q == '0;
  assign sts_o.key_gt   = key_rdata > sev_q;
  assign sts_o.out_free = !m_valid_q || m_ready_i;

  assign wr_addr   = slot_of(head_q, k_q);
  assign rd_addr   = cmd_i.rd_head ? head_q : slot_of(head_q, k_q - AW'(1));
  assign ram_we    = cmd_i.wr_new || cmd_i.wr_old;
  assign key_wdata = cmd_i.wr_new ? sev_q : key_rdata;
  assign pay_wdata = cmd_i.wr_new ? pay_q : pay_rdata;

  spq_ram #(.WIDTH(SEV_W), .DEPTH(DEPTH)) u_key_ram (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (key_wdata),
    .re_i    (cmd_i.rd_tail || cmd_i.rd_head),
    .raddr_i (rd_addr),
    .rdata_o (key_rdata)
  );

  spq_ram #(.WIDTH(PAY_W), .DEPTH(DEPTH)) u_pay_ram (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (pay_wdata),
    .re_i    (cmd_i.rd_tail || cmd_i.rd_head),
    .raddr_i (rd_addr),
    .rdata_o (pay_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        count_q <= '0;
      end else if (cmd_i.ins_done) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.pop) begin
        count_q <= count_q - CW'(1);
        head_q  <= slot_of(head_q, AW'(1));
      end
      if (cmd_i.push_out) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sev_q     <= s_data_i[FUNC_W +: SEV_W];
      pay_q     <= s_data_i[FUNC_W+SEV_W +: PAY_W];
      res_sev_q <= '0;
      res_pay_q <= '0;
    end
    if (cmd_i.load) begin
      res_ok_q <= cmd_i.clear;
    end else if (cmd_i.ins_done || cmd_i.pop) begin
      res_ok_q <= 1'b1;
    end
    if (cmd_i.pop) begin
      res_sev_q <= key_rdata;
      res_pay_q <= pay_rdata;
    end
    if (cmd_i.set_k) begin
      k_q <= count_q[AW-1:0];
    end else if (cmd_i.dec_k) begin
      k_q <= k_q - AW'(1);
    end
    if (cmd_i.push_out) begin
      m_data_q <= OUT_W'({count_q, res_pay_q, res_sev_q, res_ok_q});
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;

endmodule

// ===== rtl/sorted_priority_queue_core.sv =====
// Throughput: one request at a time; an insert walks the tail through one RAM
//   read and one write per moved entry.
// Reset: head slot and count clear at once; the entry RAMs are not cleared.
module sorted_priority_queue_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // func[1:0], severity[9:2], payload[41:10], zero pad
  input  logic [spq_pkg::IN_W-1:0]              s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // ok[0], out_severity[8:1], out_payload[40:9], occupancy above, zero pad
  output logic [((41+$clog2(DEPTH+1)+7)/8)*8-1:0] m_axis_tdata_o
);
  import spq_pkg::*;

  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned OUT_W = ((41 + CW + 7) / 8) * 8;

  cmd_t cmd;
  sts_t sts;

  spq_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  spq_dp #(.DEPTH(DEPTH), .OUT_W(OUT_W)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i     (cmd),
    .sts_o     (sts),
    .s_valid_i (s_axis_tvalid_i),
    .s_data_i  (s_axis_tdata_i),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o)
  );

  assign s_axis_tready_o = cmd.in_ready;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("accepted a beat while busy");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[41 +: CW] <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[40:1] == '0)
    else $error("failed request carries entry data");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clear, cmd.ins_done, cmd.pop}))
    else $error("conflicting count updates");

endmodule

// ===== tb/sorted_priority_queue_core_tb.sv =====
`timescale 1ns / 1ps

module sorted_priority_queue_core_tb;

  import spq_pkg::*;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned OUT_W      = ((41 + $clog2(DEPTH + 1) + 7) / 8) * 8;
  localparam int unsigned CYCLE_CAP  = 1000000;
  localparam int unsigned SETTLE     = 40;
  localparam int unsigned MAX_REPORT = 40;
  localparam logic [FUNC_W-1:0] FUNC_UNDEF = 2'd3;

  typedef struct packed {
    logic             ok;
    logic [SEV_W-1:0] sev;
    logic [PAY_W-1:0] pay;
    logic [4:0]       occ;
  } reply_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [IN_W-1:0]  s_axis_tdata_i = '0;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata_o;

  // queue image: circular severity/payload slots
  logic [SEV_W-1:0] shadow_sev [DEPTH];
  logic [PAY_W-1:0] shadow_pay [DEPTH];
  int unsigned      shadow_head;
  int unsigned      shadow_count;

  reply_t      queue_replies [$];
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned stall_left = 0;
  bit          steady_flow;

  sorted_priority_queue_core #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (steady_flow || r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // sink stall
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (steady_flow || $urandom_range(99) < 70) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      m_axis_tready_i <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  function automatic reply_t pq_apply(input logic [FUNC_W-1:0] f,
                                      input logic [SEV_W-1:0] sev,
                                      input logic [PAY_W-1:0] pay);
    reply_t      r;
    int unsigned pos;
    int unsigned k;
    r = '0;
    case (f)
      FUNC_INSERT: begin
        if (shadow_count < DEPTH) begin
          pos = 0;
          while (pos < shadow_count && shadow_sev[(shadow_head + pos) % DEPTH] > sev) pos++;
          for (k = shadow_count; k > pos; k--) begin
            shadow_sev[(shadow_head + k) % DEPTH] = shadow_sev[(shadow_head + k - 1) % DEPTH];
            shadow_pay[(shadow_head + k) % DEPTH] = shadow_pay[(shadow_head + k - 1) % DEPTH];
          end
          shadow_sev[(shadow_head + pos) % DEPTH] = sev;
          shadow_pay[(shadow_head + pos) % DEPTH] = pay;
          shadow_count++;
          r.ok = 1'b1;
        end
      end
      FUNC_REMOVE: begin
        if (shadow_count != 0) begin
          r.sev = shadow_sev[shadow_head];
          r.pay = shadow_pay[shadow_head];
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_count--;
          r.ok = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        if (shadow_count != 0) begin
          shadow_count = 0;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.occ = 5'(shadow_count);
    return r;
  endfunction

  // valid stays high across back-to-back beats; lowered here only before a gap
  task automatic push_request(input logic [FUNC_W-1:0] f,
                              input logic [SEV_W-1:0] sev,
                              input logic [PAY_W-1:0] pay);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'd0, pay, sev, f};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    queue_replies.push_back(pq_apply(f, sev, pay));
  endtask

  task automatic wait_drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (queue_replies.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    reply_t got;
    reply_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.ok  = m_axis_tdata_o[0];
      got.sev = m_axis_tdata_o[8:1];
      got.pay = m_axis_tdata_o[40:9];
      got.occ = m_axis_tdata_o[45:41];
      if (queue_replies.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORT)
          $display("%0t: unexpected beat ok=%0b sev=%02h pay=%08h occ=%0d",
                   $time, got.ok, got.sev, got.pay, got.occ);
      end else begin
        want = queue_replies.pop_front();
        if (got !== want) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORT)
            $display("%0t: mismatch exp ok=%0b sev=%02h pay=%08h occ=%0d,",
                     $time, want.ok, want.sev, want.pay, want.occ,
                     " got ok=%0b sev=%02h pay=%08h occ=%0d",
                     got.ok, got.sev, got.pay, got.occ);
        end
      end
    end
  end

  task automatic test_empty_requests();
    push_request(FUNC_REMOVE, 8'h00, 32'h0);
    push_request(FUNC_CLEAR, 8'hFF, 32'hFFFF_FFFF);
    push_request(FUNC_UNDEF, 8'h5A, 32'hA5A5_A5A5);
    wait_drain();
  endtask

  // equal keys: newer goes ahead
  task automatic test_order_and_ties();
    push_request(FUNC_INSERT, 8'h80, 32'h0000_000A);
    push_request(FUNC_INSERT, 8'h80, 32'h0000_000B);
    push_request(FUNC_INSERT, 8'hFF, 32'hFFFF_FFFF);
    push_request(FUNC_INSERT, 8'h00, 32'h0000_0000);
    push_request(FUNC_INSERT, 8'h80, 32'h0000_000C);
    push_request(FUNC_REMOVE, 8'h00, 32'h0);
    push_request(FUNC_REMOVE, 8'h00, 32'h0);
    push_request(FUNC_CLEAR, 8'h00, 32'h0);
    wait_drain();
  endtask

  // head is past slot 0 here, so filling wraps the slots
  task automatic test_full_and_wrap();
    int i;
    for (i = 0; i < DEPTH; i++)
      push_request(FUNC_INSERT, 8'($urandom_range(255)), $urandom());
    push_request(FUNC_INSERT, 8'hFF, 32'hDEAD_BEEF);
    push_request(FUNC_UNDEF, 8'h00, 32'h0);
    push_request(FUNC_REMOVE, 8'h00, 32'h0);
    wait_drain();
  endtask

  task automatic test_random_traffic();
    int          round;
    int          i;
    int unsigned bias;
    int unsigned key_mode;
    int unsigned base;
    int unsigned r;
    logic [FUNC_W-1:0] f;
    logic [SEV_W-1:0]  sev;
    for (round = 0; round < 11; round++) begin
      bias        = $urandom_range(2);
      key_mode    = $urandom_range(2);
      base        = $urandom_range(252);
      steady_flow = (round % 4 == 3);
      if (round == 5) wait_drain();
      for (i = 0; i < 100; i++) begin
        r = $urandom_range(99);
        if (r < 4) begin
          f = FUNC_UNDEF;
        end else if (r < 5) begin
          f = FUNC_CLEAR;
        end else begin
          case (bias)
            0:       f = (r < 80) ? FUNC_INSERT : FUNC_REMOVE;
            1:       f = (r < 25) ? FUNC_INSERT : FUNC_REMOVE;
            default: f = (r < 52) ? FUNC_INSERT : FUNC_REMOVE;
          endcase
        end
        case (key_mode)
          0:       sev = 8'($urandom_range(255));
          1:       sev = 8'(base + $urandom_range(3));
          default: sev = $urandom_range(1) ? 8'hFF : 8'h00;
        endcase
        push_request(f, sev, $urandom());
      end
    end
    steady_flow = 1'b0;
    wait_drain();
  endtask

  initial begin
    steady_flow  = 1'b0;
    shadow_head  = 0;
    shadow_count = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_requests();
    test_order_and_ties();
    test_full_and_wrap();
    test_random_traffic();

    repeat (SETTLE) @(posedge clk_i);
    if (err_cnt == 0 && queue_replies.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
